FILE: rtl/core/abs_pkg.sv
// package for the adaptive bitrate selector: widths, codes and item types
// no dependencies
`timescale 1ns / 1ps
package abs_pkg;
  localparam int MAX_STREAMS   = 8;
  localparam int STREAM_AW     = 3;
  localparam int CNT_W         = 4;
  localparam int HIST_DEPTH    = 16;
  localparam int HIST_AW       = 4;
  localparam int FILL_W        = 5;
  localparam int RATE_W        = 32;
  localparam int BYTE_W        = 24;
  localparam int TIME_W        = 32;
  localparam int BYTES_W       = 28;
  localparam int SPAN_W        = 37;
  localparam int DIV_W         = 41;
  localparam int REM_W         = 38;
  localparam int DIV_CNT_W     = 6;
  localparam int SPEED_W       = 31;
  localparam int QUOT_W        = 25;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int HIST_DW       = BYTE_W + TIME_W;

  localparam logic [12:0] BITS_PER_KBYTE = 13'd8000;
  localparam logic [6:0]  PCT_DIV        = 7'd100;
  localparam logic [6:0]  PCT_MUL        = 7'd75;
  localparam logic [DIV_W-1:0] SPEED_MAX = DIV_W'(32'h7FFF_FFFF);

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CHUNK = 2'd2;
  localparam logic [1:0] KIND_CHECK = 2'd3;

  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_TOO_SOON = 3'd1;
  localparam logic [2:0] ST_NO_CHG   = 3'd2;
  localparam logic [2:0] ST_DEFERRED = 3'd3;
  localparam logic [2:0] ST_SWITCHED = 3'd4;
  localparam logic [2:0] ST_REFUSED  = 3'd5;

  localparam logic [CFG_AW-1:0] CFG_STREAM_COUNT = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_INITIAL_IDX  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_START_TIME   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_WINDOW       = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_INTERVAL     = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_EARLY_LIMIT  = 3'd5;

  typedef struct packed {
    logic [1:0]           kind;
    logic [TIME_W-1:0]    now_ms;
    logic [BYTE_W-1:0]    byte_count;
    logic [TIME_W-1:0]    play_time_ms;
    logic [STREAM_AW-1:0] table_index;
    logic [RATE_W-1:0]    rate_value;
    logic                 switch_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [STREAM_AW-1:0] selected_index;
    logic                 seek_request;
    logic [TIME_W-1:0]    seek_time_ms;
    logic [SPEED_W-1:0]   scaled_speed;
  } out_item_t;
endpackage

FILE: rtl/core/abs_in_if.sv
// input channel of the adaptive bitrate selector
// depends on abs_pkg
`timescale 1ns / 1ps
interface abs_in_if;
  logic             valid;
  logic             ready;
  abs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/abs_out_if.sv
// output channel of the adaptive bitrate selector
// depends on abs_pkg
`timescale 1ns / 1ps
interface abs_out_if;
  logic              valid;
  logic              ready;
  abs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/adaptive_bitrate_selector.sv
// adaptive bitrate selector top level: bitrate table, download history,
// bit-serial speed estimate and stream choice; uses abs_pkg, abs_in_if, abs_out_if, abs_ram
//
//   channel   | dir | handshake        | payload
//   in_ch     | in  | valid / ready    | kind, now_ms, byte_count, play_time_ms, ...
//   out_ch    | out | valid / ready    | status, selected_index, seek, seek time, speed
//   cfg       | in  | cfg_we           | cfg_index, cfg_data
//
// load, start, chunk and ignored checks go straight from idle to finish; a full check walks
// the history, multiplies, divides twice, scales, scans the streams and picks, a too soon check
// stops after the scale: the history walk reads one ram entry at a time through a read and an
// accumulate state, and the shared restoring divider retires one bit a cycle.
// one item at a time; ready is low while an item is at work.
// rst is synchronous, sets the configuration to its defaults and clears pointers and handshake state.
// a result held by a stalled sink blocks only the next completion, not the next transfer.
`timescale 1ns / 1ps
module adaptive_bitrate_selector (
  input  logic                          clk,
  input  logic                          rst,
  abs_in_if.sink                        in_ch,
  abs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [abs_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [abs_pkg::CFG_DW-1:0]    cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_WALK_RD, S_WALK_ACC, S_MUL, S_DIV, S_PCT, S_SCALE,
    S_SEL_RD, S_SEL_CMP, S_PICK_RD, S_PICK_CMP, S_FINISH
  } state_t;

  state_t state;

  logic [abs_pkg::CNT_W-1:0]     stream_count;
  logic [abs_pkg::TIME_W-1:0]    start_check_time;
  logic [abs_pkg::TIME_W-1:0]    speed_window;
  logic [15:0]                   check_interval;
  logic [7:0]                    early_change_limit;

  logic [abs_pkg::HIST_AW-1:0]   hist_head;
  logic [abs_pkg::FILL_W-1:0]    hist_fill;
  logic [abs_pkg::TIME_W-1:0]    mark_time;
  logic [abs_pkg::TIME_W-1:0]    last_check_time;
  logic [abs_pkg::STREAM_AW-1:0] current_index;
  logic [7:0]                    change_count;

  logic [abs_pkg::TIME_W-1:0]    item_now;
  logic [abs_pkg::TIME_W-1:0]    item_play;
  logic                          item_ok;
  logic                          too_soon;

  logic [abs_pkg::HIST_AW-1:0]   walk_ptr;
  logic [abs_pkg::FILL_W-1:0]    walk_k;
  logic [abs_pkg::BYTES_W-1:0]   bytes_sum;
  logic [abs_pkg::SPAN_W-1:0]    span_sum;

  logic [abs_pkg::DIV_W-1:0]     div_num;
  logic [abs_pkg::SPAN_W-1:0]    div_den;
  logic [abs_pkg::REM_W-1:0]     div_rem;
  logic [abs_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          div_pct;

  logic [abs_pkg::SPEED_W-1:0]   speed;
  logic [abs_pkg::CNT_W-1:0]     scan_i;
  logic                          gt0;
  logic                          found;
  logic [abs_pkg::CNT_W-1:0]     first_lt;
  logic [abs_pkg::STREAM_AW-1:0] sel_idx;

  logic [2:0]                    res_status;
  logic                          res_seek;

  logic                          out_valid;
  abs_pkg::out_item_t            out_data;

  logic [abs_pkg::CNT_W-1:0]     n_act;
  logic                          rate_we;
  logic [abs_pkg::STREAM_AW-1:0] rate_raddr;
  logic [abs_pkg::RATE_W-1:0]    rate_rdata;
  logic                          hist_we;
  logic [abs_pkg::HIST_DW-1:0]   hist_wdata;
  logic [abs_pkg::HIST_DW-1:0]   hist_rdata;
  logic                          accept;

  logic [abs_pkg::SPAN_W-1:0]    span_next;
  logic [abs_pkg::BYTES_W-1:0]   bytes_next;
  logic [abs_pkg::REM_W-1:0]     rem_sh;
  logic                          rem_ge;
  logic [abs_pkg::DIV_W-1:0]     prod;
  logic                          lt_now;
  logic [abs_pkg::CNT_W-1:0]     first_eff;
  logic [abs_pkg::STREAM_AW-1:0] sel_final;
  logic                          up;
  logic                          early;
  logic [7:0]                    cc_early;

  function automatic logic [7:0] bump(input logic [7:0] c);
    bump = (c == 8'd255) ? c : c + 8'd1;
  endfunction

  assign n_act  = (stream_count > abs_pkg::CNT_W'(abs_pkg::MAX_STREAMS))
                ? abs_pkg::CNT_W'(abs_pkg::MAX_STREAMS) : stream_count;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign rate_we    = accept && (in_ch.data.kind == abs_pkg::KIND_LOAD);
  assign hist_we    = accept && (in_ch.data.kind == abs_pkg::KIND_CHUNK) && (n_act > 4'd1);
  assign hist_wdata = {in_ch.data.byte_count, in_ch.data.now_ms - mark_time};
  assign rate_raddr = (state == S_PICK_RD) ? sel_idx : scan_i[abs_pkg::STREAM_AW-1:0];

  abs_ram #(.WIDTH(abs_pkg::RATE_W), .DEPTH(abs_pkg::MAX_STREAMS)) u_rate_ram (
    .clk(clk), .we(rate_we), .waddr(in_ch.data.table_index),
    .wdata(in_ch.data.rate_value), .raddr(rate_raddr), .rdata(rate_rdata)
  );

  abs_ram #(.WIDTH(abs_pkg::HIST_DW), .DEPTH(abs_pkg::HIST_DEPTH)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(hist_head),
    .wdata(hist_wdata), .raddr(walk_ptr), .rdata(hist_rdata)
  );

  always_comb begin
    bytes_next = bytes_sum + abs_pkg::BYTES_W'(hist_rdata[abs_pkg::HIST_DW-1:abs_pkg::TIME_W]);
    span_next  = span_sum + abs_pkg::SPAN_W'(hist_rdata[abs_pkg::TIME_W-1:0]);
    prod       = abs_pkg::DIV_W'(bytes_sum) * abs_pkg::DIV_W'(abs_pkg::BITS_PER_KBYTE);
    rem_sh     = {div_rem[abs_pkg::REM_W-2:0], div_num[abs_pkg::DIV_W-1]};
    rem_ge     = rem_sh >= {1'b0, div_den};
    lt_now     = {1'b0, speed} < rate_rdata;
    first_eff  = found ? first_lt : scan_i;
    if (!lt_now) begin
      sel_final = abs_pkg::STREAM_AW'(n_act - 4'd1);
    end else if (gt0 || (scan_i == '0 && ({1'b0, speed} > rate_rdata))) begin
      sel_final = abs_pkg::STREAM_AW'(first_eff - 4'd1);
    end else begin
      sel_final = '0;
    end
    up       = sel_idx > current_index;
    early    = up && (change_count <= early_change_limit);
    cc_early = early ? bump(change_count) : change_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      stream_count       <= '0;
      start_check_time   <= '0;
      speed_window       <= abs_pkg::TIME_W'(5000);
      check_interval     <= 16'd2000;
      early_change_limit <= 8'd4;
      hist_head          <= '0;
      hist_fill          <= '0;
      mark_time          <= '0;
      last_check_time    <= '0;
      current_index      <= '0;
      change_count       <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          abs_pkg::CFG_STREAM_COUNT: stream_count <= cfg_data[abs_pkg::CNT_W-1:0];
          abs_pkg::CFG_INITIAL_IDX:  current_index <= cfg_data[abs_pkg::STREAM_AW-1:0];
          abs_pkg::CFG_START_TIME:  start_check_time   <= cfg_data;
          abs_pkg::CFG_WINDOW:      speed_window       <= cfg_data;
          abs_pkg::CFG_INTERVAL:    check_interval     <= cfg_data[15:0];
          abs_pkg::CFG_EARLY_LIMIT: early_change_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_now   <= in_ch.data.now_ms;
            item_play  <= in_ch.data.play_time_ms;
            item_ok    <= in_ch.data.switch_ok;
            too_soon   <= (in_ch.data.now_ms - last_check_time) <
                          abs_pkg::TIME_W'(check_interval);
            res_status <= abs_pkg::ST_IGNORED;
            res_seek   <= 1'b0;
            speed      <= '0;
            bytes_sum  <= '0;
            span_sum   <= abs_pkg::SPAN_W'(1);
            walk_ptr   <= hist_head - abs_pkg::HIST_AW'(1);
            walk_k     <= '0;
            state      <= S_FINISH;
            case (in_ch.data.kind)
              abs_pkg::KIND_START: mark_time <= in_ch.data.now_ms;
              abs_pkg::KIND_CHUNK: begin
                if (n_act > 4'd1) begin
                  mark_time <= in_ch.data.now_ms;
                  hist_head <= hist_head + abs_pkg::HIST_AW'(1);
                  if (hist_fill < abs_pkg::FILL_W'(abs_pkg::HIST_DEPTH)) begin
                    hist_fill <= hist_fill + abs_pkg::FILL_W'(1);
                  end
                end
              end
              abs_pkg::KIND_CHECK: begin
                if (n_act > 4'd1 && in_ch.data.play_time_ms > start_check_time) begin
                  state <= (hist_fill == '0) ? S_MUL : S_WALK_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK_RD: state <= S_WALK_ACC;
        S_WALK_ACC: begin
          bytes_sum <= bytes_next;
          span_sum  <= span_next;
          walk_k    <= walk_k + abs_pkg::FILL_W'(1);
          walk_ptr  <= walk_ptr - abs_pkg::HIST_AW'(1);
          if (span_next >= abs_pkg::SPAN_W'(speed_window) ||
              walk_k + abs_pkg::FILL_W'(1) == hist_fill) begin
            state <= S_MUL;
          end else begin
            state <= S_WALK_RD;
          end
        end
        S_MUL: begin
          div_num <= prod;
          div_den <= span_sum;
          div_rem <= '0;
          div_cnt <= '0;
          div_pct <= 1'b0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_rem <= rem_ge ? rem_sh - {1'b0, div_den} : rem_sh;
          div_num <= {div_num[abs_pkg::DIV_W-2:0], rem_ge};
          div_cnt <= div_cnt + abs_pkg::DIV_CNT_W'(1);
          if (div_cnt == abs_pkg::DIV_CNT_W'(abs_pkg::DIV_W - 1)) begin
            state <= div_pct ? S_SCALE : S_PCT;
          end
        end
        S_PCT: begin
          // saturate, then divide by 100 on the same unit
          div_num <= (div_num > abs_pkg::SPEED_MAX) ? abs_pkg::SPEED_MAX : div_num;
          div_den <= abs_pkg::SPAN_W'(abs_pkg::PCT_DIV);
          div_rem <= '0;
          div_cnt <= '0;
          div_pct <= 1'b1;
          state   <= S_DIV;
        end
        S_SCALE: begin
          speed  <= abs_pkg::SPEED_W'(div_num[abs_pkg::QUOT_W-1:0]) *
                    abs_pkg::SPEED_W'(abs_pkg::PCT_MUL);
          scan_i <= '0;
          found  <= 1'b0;
          gt0    <= 1'b0;
          if (too_soon) begin
            res_status <= abs_pkg::ST_TOO_SOON;
            state      <= S_FINISH;
          end else begin
            last_check_time <= item_now;
            state           <= S_SEL_RD;
          end
        end
        S_SEL_RD: state <= S_SEL_CMP;
        S_SEL_CMP: begin
          if (scan_i == '0) begin
            gt0 <= {1'b0, speed} > rate_rdata;
          end
          if (!found && lt_now) begin
            found    <= 1'b1;
            first_lt <= scan_i;
          end
          if (scan_i == n_act - 4'd1) begin
            sel_idx <= sel_final;
            state   <= S_PICK_RD;
          end else begin
            scan_i <= scan_i + 4'd1;
            state  <= S_SEL_RD;
          end
        end
        S_PICK_RD: state <= S_PICK_CMP;
        S_PICK_CMP: begin
          state <= S_FINISH;
          if (sel_idx == current_index) begin
            res_status <= abs_pkg::ST_NO_CHG;
          end else if (early && ({2'b0, speed} < {rate_rdata, 1'b0})) begin
            change_count <= cc_early;
            res_status   <= abs_pkg::ST_DEFERRED;
          end else if (item_ok) begin
            change_count  <= bump(cc_early);
            current_index <= sel_idx;
            res_seek      <= up;
            res_status    <= abs_pkg::ST_SWITCHED;
          end else begin
            change_count <= cc_early;
            res_status   <= abs_pkg::ST_REFUSED;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid               <= 1'b1;
            out_data.status         <= res_status;
            out_data.selected_index <= current_index;
            out_data.seek_request   <= res_seek;
            out_data.seek_time_ms   <= res_seek ? item_play : '0;
            out_data.scaled_speed   <= speed;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/abs_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module abs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/abs_checker.sv
// port level checks for the adaptive bitrate selector, bound to the top level
// depends on abs_pkg
`timescale 1ns / 1ps
module abs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    status,
  input logic                          seek_request,
  input logic [abs_pkg::TIME_W-1:0]    seek_time_ms
);
  // a held result stays valid with a stable status until its transfer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= abs_pkg::ST_REFUSED)
    else $error("status code out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && seek_request |-> status == abs_pkg::ST_SWITCHED)
    else $error("seek without switch");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !seek_request |-> seek_time_ms == '0)
    else $error("seek time without seek");

  // one item at a time: no new transfer right after one
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
endmodule

bind adaptive_bitrate_selector abs_checker u_abs_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.data.status), .seek_request(out_ch.data.seek_request),
  .seek_time_ms(out_ch.data.seek_time_ms)
);
